// ===== hdl/cht_pkg.sv =====
package cht_pkg;

	// Operation codes of a request
	localparam logic [1:0] OP_ADD    = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;
	localparam logic [1:0] OP_QUERY  = 2'd2;

	// Report limits
	localparam logic signed [7:0] RSSI_FLOOR = -8'sd100;
	localparam logic [7:0]        ID_CEILING = 8'd255;
	localparam logic [7:0]        SINK_ID    = 8'h01;

	// Configuration register index (paddr[2])
	localparam logic REG_OWN_ID = 1'b0;

	// Token that walks the row of entry cells, one cell per cycle
	typedef struct packed {
		logic              valid;
		logic [1:0]        operation;
		logic [7:0]        node_id;
		logic signed [7:0] strength;
		logic              full;
		logic              placed;
		logic              best_ok;
		logic [7:0]        best_node;
		logic signed [7:0] best_strength;
		logic [2:0]        best_slot;
		logic              min_ok;
		logic [7:0]        min_id;
	} carry_t;

endpackage

// ===== hdl/cht_if.sv =====
interface cht_in_if;
	logic              valid;
	logic              ready;
	logic [1:0]        operation;
	logic [7:0]        node_id;
	logic signed [7:0] signal_strength;

	modport source (output valid, output operation, output node_id, output signal_strength,
		input ready);
	modport sink (input valid, input operation, input node_id, input signal_strength,
		output ready);
endinterface

interface cht_out_if;
	logic              valid;
	logic              ready;
	logic              best_found;
	logic [7:0]        best_node;
	logic signed [7:0] best_strength;
	logic [2:0]        best_slot;
	logic              next_found;
	logic [7:0]        next_node;

	modport source (output valid, output best_found, output best_node,
		output best_strength, output best_slot, output next_found, output next_node,
		input ready);
	modport sink (input valid, input best_found, input best_node,
		input best_strength, input best_slot, input next_found, input next_node,
		output ready);
endinterface

// ===== hdl/cht_cell.sv =====
module cht_cell import cht_pkg::*; #(
	parameter int TABLE_DEPTH = 8,
	parameter int INDEX       = 0,
	localparam int IW         = $clog2(TABLE_DEPTH)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [IW-1:0] victim,
	input  carry_t        cin,
	output carry_t        cout,
	output logic          avail
);

	logic              avail_q;
	logic [7:0]        id_q;
	logic signed [7:0] strength_q;
	carry_t            carry_q;

	logic              take;
	logic              drop;
	logic              new_avail;
	logic [7:0]        new_id;
	logic signed [7:0] new_strength;
	carry_t            nxt;

	// Decide what the passing request does to this entry
	always_comb begin
		take = cin.valid && (cin.operation == OP_ADD) &&
			(cin.full ? (victim == IW'(INDEX)) : (!cin.placed && !avail_q));
		drop = cin.valid && (cin.operation == OP_REMOVE) && (id_q == cin.node_id);
		new_avail    = take ? 1'b1 : (drop ? 1'b0 : avail_q);
		new_id       = take ? cin.node_id : id_q;
		new_strength = take ? cin.strength : strength_q;
	end

	// Fold this entry into the running reports; earlier slots win ties
	always_comb begin
		nxt = cin;
		if (take) begin
			nxt.placed = 1'b1;
		end
		if (new_avail && ($signed(new_strength) > $signed(cin.best_strength))) begin
			nxt.best_ok       = 1'b1;
			nxt.best_node     = new_id;
			nxt.best_strength = new_strength;
			nxt.best_slot     = 3'(INDEX);
		end
		if (new_avail && (new_id < cin.min_id)) begin
			nxt.min_ok = 1'b1;
			nxt.min_id = new_id;
		end
	end

	// Hold the entry flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avail_q <= 1'b0;
		end else if (cin.valid) begin
			avail_q <= new_avail;
		end
	end

	// Hold the entry payload
	always_ff @(posedge clk) begin
		if (take) begin
			id_q       <= cin.node_id;
			strength_q <= cin.strength;
		end
	end

	// Hand the token to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			carry_q <= '0;
		end else begin
			carry_q <= nxt;
		end
	end

	assign cout  = carry_q;
	assign avail = avail_q;

endmodule

// ===== hdl/cluster_head_table.sv =====
// Cluster head table: a row of TABLE_DEPTH entry cells walked by one request token.
// Each request is registered at the head, passes through the carry register of every cell
// in turn and is then captured in the result register. The token visits one cell per
// cycle, and the next request is taken after the result has been taken.
// Reset (arst_n, asynchronous, active low) clears all entry flags, the replace
// pointer and own_node_id; entry ids and strengths are don't-care while cleared.
module cluster_head_table import cht_pkg::*; #(
	parameter int TABLE_DEPTH = 8,
	localparam int IW         = $clog2(TABLE_DEPTH)
) (
	input  logic        clk,
	input  logic        arst_n,
	cht_in_if.sink      req,
	cht_out_if.source   rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic                   busy_q;
	logic [IW-1:0]          rptr_q;
	logic [IW-1:0]          victim_q;
	logic [7:0]             own_id_q;
	carry_t                 head_q;
	carry_t                 chain [TABLE_DEPTH+1];
	logic [TABLE_DEPTH-1:0] avail_vec;
	logic [TABLE_DEPTH:0]   chain_valid;
	logic                   full;
	logic                   req_take;
	logic                   rsp_take;
	carry_t                 last;

	assign full     = &avail_vec;
	assign req_take = req.valid && req.ready;
	assign rsp_take = rsp.valid && rsp.ready;
	assign req.ready = !busy_q;
	assign last     = chain[TABLE_DEPTH];

	// Configuration port
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_OWN_ID) ? {24'd0, own_id_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_id_q <= '0;
		end else if (psel && penable && pwrite && (paddr[2] == REG_OWN_ID)) begin
			own_id_q <= pwdata[7:0];
		end
	end

	// Launch a token per request and advance the replace pointer on a full add
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			rptr_q   <= '0;
			victim_q <= '0;
			head_q   <= '0;
		end else begin
			head_q.valid <= 1'b0;
			if (req_take) begin
				busy_q               <= 1'b1;
				victim_q             <= rptr_q;
				head_q.valid         <= 1'b1;
				head_q.operation     <= req.operation;
				head_q.node_id       <= req.node_id;
				head_q.strength      <= req.signal_strength;
				head_q.full          <= full;
				head_q.placed        <= 1'b0;
				head_q.best_ok       <= 1'b0;
				head_q.best_node     <= '0;
				head_q.best_strength <= RSSI_FLOOR;
				head_q.best_slot     <= '0;
				head_q.min_ok        <= 1'b0;
				head_q.min_id        <= ID_CEILING;
				if ((req.operation == OP_ADD) && full) begin
					rptr_q <= (rptr_q == IW'(TABLE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
				end
			end else if (rsp_take) begin
				busy_q <= 1'b0;
			end
		end
	end

	assign chain[0] = head_q;

	// Row of entry cells
	for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
		cht_cell #(
			.TABLE_DEPTH (TABLE_DEPTH),
			.INDEX       (k)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.victim (victim_q),
			.cin    (chain[k]),
			.cout   (chain[k+1]),
			.avail  (avail_vec[k])
		);
	end

	for (genvar k = 0; k <= TABLE_DEPTH; k++) begin : g_valid
		assign chain_valid[k] = chain[k].valid;
	end

	// Result register: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.valid <= 1'b0;
		end else if (last.valid) begin
			rsp.valid <= 1'b1;
		end else if (rsp_take) begin
			rsp.valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (last.valid) begin
			rsp.best_found    <= last.best_ok;
			rsp.best_node     <= last.best_ok ? last.best_node : 8'd0;
			rsp.best_strength <= last.best_ok ? last.best_strength : 8'sd0;
			rsp.best_slot     <= last.best_ok ? last.best_slot : 3'd0;
			rsp.next_found    <= last.min_ok && (own_id_q != SINK_ID);
			rsp.next_node     <= (last.min_ok && (own_id_q != SINK_ID)) ? last.min_id : 8'd0;
		end
	end

	// Checks
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(chain_valid))
		else $error("more than one token in the cell row");

	a_idle_no_token: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> (chain_valid == '0) && !rsp.valid)
		else $error("token or result present while idle");

	a_launch: assert property (@(posedge clk) disable iff (!arst_n)
		req_take |=> head_q.valid && busy_q)
		else $error("request taken without launching a token");

	a_result_busy: assert property (@(posedge clk) disable iff (!arst_n)
		last.valid |=> rsp.valid && busy_q)
		else $error("finished token did not reach the result register");

endmodule

// ===== verif/tb_cluster_head_table.sv =====
`timescale 1ns / 1ps
module tb_cluster_head_table;
	import cht_pkg::*;

	localparam int DEPTH = 8;
	// Operation code with no meaning of its own; the block treats it as a query
	localparam logic [1:0] OP_SPARE = 2'd3;
	localparam int SHOW_LIMIT = 40;
	localparam int SETTLE_CYCLES = DEPTH + 6;

	typedef struct packed {
		logic              best_found;
		logic [7:0]        best_node;
		logic signed [7:0] best_strength;
		logic [2:0]        best_slot;
		logic              next_found;
		logic [7:0]        next_node;
	} head_report_t;

	// Mirror of the head table and the queue of reports it predicts
	class head_table_scoreboard;
		logic [7:0]        head_id[DEPTH];
		logic signed [7:0] head_rssi[DEPTH];
		bit                head_live[DEPTH];
		int                used_slots;
		int                evict_slot;
		logic [7:0]        own_id;
		head_report_t      expected_reports[$];
		int                errors;

		function new();
			foreach (head_id[i]) begin
				head_id[i] = '0;
				head_rssi[i] = '0;
				head_live[i] = 1'b0;
			end
			used_slots = 0;
			evict_slot = 0;
			own_id = '0;
			errors = 0;
		endfunction

		function int pending();
			return expected_reports.size();
		endfunction

		task report(string what, int got, int want);
			if (errors < SHOW_LIMIT)
				$display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
			errors++;
		endtask

		// Apply one request to the mirror and queue the report it must produce
		function void note_request(logic [1:0] op, logic [7:0] id, logic signed [7:0] rssi);
			int                i;
			int                slot;
			bit                free_seen;
			logic signed [7:0] best_rssi;
			int                lowest;
			head_report_t      rep;

			slot = 0;
			free_seen = 1'b0;
			if (op == OP_ADD) begin
				if (used_slots < DEPTH)
					used_slots++;
				for (i = 0; i < used_slots; i++) begin
					if (!free_seen && !head_live[i]) begin
						slot = i;
						free_seen = 1'b1;
					end
				end
				// no hole among the counted slots: overwrite round robin
				if (!free_seen) begin
					slot = evict_slot;
					evict_slot = (evict_slot + 1 >= DEPTH) ? 0 : evict_slot + 1;
				end
				head_id[slot] = id;
				head_rssi[slot] = rssi;
				head_live[slot] = 1'b1;
			end else if (op == OP_REMOVE) begin
				for (i = 0; i < used_slots; i++)
					if (head_id[i] == id)
						head_live[i] = 1'b0;
			end

			// strongest head above the floor, lowest id below the ceiling; first slot wins ties
			rep = '0;
			best_rssi = RSSI_FLOOR;
			lowest = ID_CEILING;
			for (i = 0; i < used_slots; i++) begin
				if (head_live[i]) begin
					if (head_rssi[i] > best_rssi) begin
						best_rssi = head_rssi[i];
						rep.best_found = 1'b1;
						rep.best_node = head_id[i];
						rep.best_strength = head_rssi[i];
						rep.best_slot = 3'(i);
					end
					if (int'(head_id[i]) < lowest) begin
						lowest = head_id[i];
						rep.next_found = 1'b1;
						rep.next_node = head_id[i];
					end
				end
			end
			// the sink never reports a next head
			if (own_id == SINK_ID) begin
				rep.next_found = 1'b0;
				rep.next_node = '0;
			end
			expected_reports.push_back(rep);
		endfunction

		task check_report(head_report_t got);
			head_report_t want;

			if (expected_reports.size() == 0) begin
				report("result with no request outstanding", got.best_node, -1);
			end else begin
				want = expected_reports.pop_front();
				if (got.best_found !== want.best_found)
					report("best_found", got.best_found, want.best_found);
				if (got.best_node !== want.best_node)
					report("best_node", got.best_node, want.best_node);
				if (got.best_strength !== want.best_strength)
					report("best_strength", got.best_strength, want.best_strength);
				if (got.best_slot !== want.best_slot)
					report("best_slot", got.best_slot, want.best_slot);
				if (got.next_found !== want.next_found)
					report("next_found", got.next_found, want.next_found);
				if (got.next_node !== want.next_node)
					report("next_node", got.next_node, want.next_node);
			end
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	cht_in_if  req_if();
	cht_out_if rsp_if();

	int send_idle_pct;
	int recv_idle_pct;
	head_table_scoreboard sb;

	cluster_head_table #(.TABLE_DEPTH(DEPTH)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_if),
		.rsp(rsp_if),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Take results with random back-pressure and check each against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && rsp_if.valid && rsp_if.ready)
			sb.check_report('{rsp_if.best_found, rsp_if.best_node, rsp_if.best_strength,
				rsp_if.best_slot, rsp_if.next_found, rsp_if.next_node});
		rsp_if.ready <= arst_n && ($urandom_range(99) >= recv_idle_pct);
	end

	// Offer one request, idling at random first, and hold it until taken
	task send_request(logic [1:0] op, logic [7:0] id, logic signed [7:0] rssi);
		while ($urandom_range(99) < send_idle_pct) begin
			req_if.valid <= 1'b0;
			@(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.operation <= op;
		req_if.node_id <= id;
		req_if.signal_strength <= rssi;
		do
			@(posedge clk);
		while (!req_if.ready);
		sb.note_request(op, id, rssi);
	endtask

	// Drop valid and wait for every outstanding report, then let the row empty
	task settle_table();
		req_if.valid <= 1'b0;
		while (sb.pending() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write own_node_id, then read it back
	task set_own_id(logic [7:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {REG_OWN_ID, 2'b00};
		pwdata <= {24'd0, value};
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		sb.own_id = value;
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		if (prdata[7:0] !== value)
			sb.report("own_node_id read back", prdata[7:0], value);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Mostly adds and removes over a small id pool so that removes hit and the table wraps
	task run_random(int count);
		int               n;
		int               pick;
		logic [1:0]       op;
		logic [7:0]       id;
		logic signed [7:0] rssi;

		for (n = 0; n < count; n++) begin
			pick = $urandom_range(99);
			if (pick < 50)
				op = OP_ADD;
			else if (pick < 75)
				op = OP_REMOVE;
			else if (pick < 90)
				op = OP_QUERY;
			else
				op = OP_SPARE;

			pick = $urandom_range(99);
			if (pick < 65)
				id = 8'($urandom_range(0, 11));
			else if (pick < 75)
				id = ID_CEILING;
			else if (pick < 80)
				id = 8'd0;
			else
				id = 8'($urandom_range(0, 255));

			pick = $urandom_range(99);
			if (pick < 15)
				rssi = 8'(int'($urandom_range(0, 2)) - 101);
			else if (pick < 20)
				rssi = -8'sd128;
			else if (pick < 25)
				rssi = 8'sd127;
			else if (pick < 30)
				rssi = 8'sd0;
			else
				rssi = 8'($urandom_range(0, 255));

			send_request(op, id, rssi);
			// now and then hold off until the block has caught up
			if ($urandom_range(99) == 0)
				settle_table();
		end
	endtask

	initial begin
		#5_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		sb = new();
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		req_if.valid <= 1'b0;
		req_if.operation <= OP_QUERY;
		req_if.node_id <= '0;
		req_if.signal_strength <= '0;
		send_idle_pct = 28;
		recv_idle_pct = 56;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty table, floor and ceiling values, ties, repeats, removes, wrap
		set_own_id(8'h00);
		send_request(OP_QUERY, 8'h5A, 8'sd0);
		send_request(OP_SPARE, 8'd3, 8'sd50);
		send_request(OP_ADD, 8'd0, -8'sd128);
		send_request(OP_ADD, ID_CEILING, RSSI_FLOOR);
		send_request(OP_ADD, ID_CEILING, 8'sd127);
		send_request(OP_ADD, 8'd7, -8'sd99);
		send_request(OP_ADD, 8'd9, 8'sd127);
		send_request(OP_ADD, 8'd7, 8'sd5);
		send_request(OP_REMOVE, 8'd7, 8'sd0);
		send_request(OP_ADD, 8'd20, 8'sd1);
		send_request(OP_ADD, 8'd21, 8'sd2);
		send_request(OP_ADD, 8'd22, 8'sd2);
		send_request(OP_ADD, 8'd23, -8'sd1);
		send_request(OP_ADD, 8'h80, -8'sd1);
		send_request(OP_ADD, 8'h55, 8'sd127);
		send_request(OP_ADD, 8'hAA, -8'sd50);
		send_request(OP_REMOVE, 8'd0, 8'sd0);
		send_request(OP_REMOVE, 8'd99, -8'sd128);
		send_request(OP_SPARE, ID_CEILING, -8'sd128);
		settle_table();

		// Directed: the sink suppresses the next-head report
		set_own_id(SINK_ID);
		send_request(OP_QUERY, 8'd0, 8'sd0);
		send_request(OP_ADD, 8'd2, 8'sd10);
		send_request(OP_REMOVE, ID_CEILING, 8'sd0);
		settle_table();

		// Random, first the sender idling less than the receiver
		set_own_id(8'($urandom_range(2, 254)));
		run_random(360);
		settle_table();

		send_idle_pct = 56;
		recv_idle_pct = 28;
		set_own_id(8'hFF);
		run_random(360);
		settle_table();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		set_own_id(SINK_ID);
		run_random(360);
		settle_table();

		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
